### rtl/core/blw_pkg.sv
// Shared constants and types of the Bresenham line walker.
// No dependencies; used by blw_step_unit and bresenham_line_walker.
package blw_pkg;

  // Default grid edge length (points per axis).
  localparam int unsigned GridSizeDef = 64;

  // Walk direction flags, fixed at line set-up.
  typedef struct packed {
    logic major_is_x;
    logic major_step_down;
    logic minor_step_down;
  } blw_dir_t;

endpackage

### rtl/core/blw_step_unit.sv
// One Bresenham step: next point and next doubled error term.
// Depends on blw_pkg (blw_dir_t).
module blw_step_unit #(
  parameter int unsigned CoordW = 6
) (
  input  logic [CoordW-1:0]        cur_x_i,
  input  logic [CoordW-1:0]        cur_y_i,
  input  logic signed [CoordW+1:0] err_i,
  input  logic [CoordW-1:0]        delta_major_i,
  input  logic [CoordW-1:0]        delta_minor_i,
  input  blw_pkg::blw_dir_t        dir_i,
  output logic [CoordW-1:0]        nxt_x_o,
  output logic [CoordW-1:0]        nxt_y_o,
  output logic signed [CoordW+1:0] nxt_err_o
);
  import blw_pkg::*;

  localparam int unsigned ErrW = CoordW + 2;

  logic                   minor_step;
  logic signed [ErrW-1:0] two_maj;
  logic signed [ErrW-1:0] two_min;
  logic signed [ErrW-1:0] err_adj;
  logic [CoordW-1:0]      major_now;
  logic [CoordW-1:0]      minor_now;
  logic [CoordW-1:0]      major_nxt;
  logic [CoordW-1:0]      minor_nxt;

  // Strictly positive error steps the minor axis.
  assign minor_step = !err_i[ErrW-1] && (err_i != '0);
  assign two_maj    = signed'({1'b0, delta_major_i, 1'b0});
  assign two_min    = signed'({1'b0, delta_minor_i, 1'b0});
  assign err_adj    = minor_step ? (err_i - two_maj) : err_i;
  assign nxt_err_o  = err_adj + two_min;

  assign major_now = dir_i.major_is_x ? cur_x_i : cur_y_i;
  assign minor_now = dir_i.major_is_x ? cur_y_i : cur_x_i;

  // Coordinates wrap modulo 2**CoordW.
  assign major_nxt = dir_i.major_step_down ? (major_now - CoordW'(1))
                                           : (major_now + CoordW'(1));
  always_comb begin
    minor_nxt = minor_now;
    if (minor_step) begin
      minor_nxt = dir_i.minor_step_down ? (minor_now - CoordW'(1))
                                        : (minor_now + CoordW'(1));
    end
  end

  assign nxt_x_o = dir_i.major_is_x ? major_nxt : minor_nxt;
  assign nxt_y_o = dir_i.major_is_x ? minor_nxt : major_nxt;

endmodule

### rtl/core/bresenham_line_walker.sv
// Bresenham line walker top level: request intake, set-up sequencer, point output.
// Depends on blw_pkg and blw_step_unit.
//
//  Channel   Dir  Handshake             Payload
//  s_axis    in   tvalid/tready         tdata: start_x, start_y, end_x, end_y
//  m_axis    out  tvalid/tready, tlast  tdata: point_x, point_y; tlast: last_point
//
// Sequence: a request is taken in an idle cycle. Then come the set-up states
// StSetup (deltas/octant) and StInit (error term), then StWalk, which emits
// one point per cycle while the output is not stalled, at most GRID_SIZE
// points per line. Each point is registered in the output register before
// it is valid. The single step unit sets the point rate. s_axis_tready is
// high only while idle. Reset clears the sequencer and the output valid.
// A stalled output holds the point and freezes the walk; the last point
// may still wait while a new request is taken.
module bresenham_line_walker #(
  parameter int unsigned GRID_SIZE = blw_pkg::GridSizeDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic                                             s_axis_tvalid,
  output logic                                             s_axis_tready,
  // tdata from bit 0 up: start_x, start_y, end_x, end_y, zero pad
  input  logic [((4*$clog2(GRID_SIZE)+7)/8)*8-1:0]          s_axis_tdata,
  output logic                                             m_axis_tvalid,
  input  logic                                             m_axis_tready,
  // tdata from bit 0 up: point_x, point_y, zero pad
  output logic [((2*$clog2(GRID_SIZE)+7)/8)*8-1:0]          m_axis_tdata,
  // last_point
  output logic                                             m_axis_tlast
);
  import blw_pkg::*;

  localparam int unsigned CoordW = $clog2(GRID_SIZE);
  localparam int unsigned ErrW   = CoordW + 2;
  localparam int unsigned CntW   = $clog2(GRID_SIZE + 1);
  localparam int unsigned OutW   = ((2*CoordW+7)/8)*8;

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StSetup = 4'b0010,
    StInit  = 4'b0100,
    StWalk  = 4'b1000
  } state_e;

  state_e state_d, state_q;

  // Walk state
  logic [CoordW-1:0]      cur_x_q, cur_y_q;
  logic [CoordW-1:0]      end_x_q, end_y_q;
  logic [CoordW-1:0]      major_end_q;
  logic [CoordW-1:0]      delta_major_q, delta_minor_q;
  logic signed [ErrW-1:0] err_q;
  blw_dir_t               dir_q;
  logic [CntW-1:0]        cnt_q;

  // Output register
  logic                   out_valid_q;
  logic [CoordW-1:0]      out_x_q, out_y_q;
  logic                   out_last_q;

  // Set-up terms
  logic [CoordW-1:0] dx, dy;
  logic              x_down, y_down, x_major;

  // Step unit results
  logic [CoordW-1:0]      nxt_x, nxt_y;
  logic signed [ErrW-1:0] nxt_err;

  logic major_hit, walk_stop, out_load;

  assign x_down  = end_x_q < cur_x_q;
  assign y_down  = end_y_q < cur_y_q;
  assign dx      = x_down ? (cur_x_q - end_x_q) : (end_x_q - cur_x_q);
  assign dy      = y_down ? (cur_y_q - end_y_q) : (end_y_q - cur_y_q);
  assign x_major = dx >= dy;  // tie goes to x

  blw_step_unit #(
    .CoordW(CoordW)
  ) u_step (
    .cur_x_i      (cur_x_q),
    .cur_y_i      (cur_y_q),
    .err_i        (err_q),
    .delta_major_i(delta_major_q),
    .delta_minor_i(delta_minor_q),
    .dir_i        (dir_q),
    .nxt_x_o      (nxt_x),
    .nxt_y_o      (nxt_y),
    .nxt_err_o    (nxt_err)
  );

  assign major_hit = (dir_q.major_is_x ? cur_x_q : cur_y_q) == major_end_q;
  // Result count is capped at GRID_SIZE points.
  assign walk_stop = major_hit || (cnt_q == CntW'(GRID_SIZE - 1));
  assign out_load  = (state_q == StWalk) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (s_axis_tvalid) state_d = StSetup;
      StSetup: state_d = StInit;
      StInit:  state_d = StWalk;
      StWalk:  if (out_load && walk_stop) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers, no reset needed.
  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        if (s_axis_tvalid) begin
          cur_x_q <= s_axis_tdata[CoordW-1:0];
          cur_y_q <= s_axis_tdata[2*CoordW-1:CoordW];
          end_x_q <= s_axis_tdata[3*CoordW-1:2*CoordW];
          end_y_q <= s_axis_tdata[4*CoordW-1:3*CoordW];
        end
      end
      StSetup: begin
        dir_q.major_is_x      <= x_major;
        dir_q.major_step_down <= x_major ? x_down : y_down;
        dir_q.minor_step_down <= x_major ? y_down : x_down;
        delta_major_q         <= x_major ? dx : dy;
        delta_minor_q         <= x_major ? dy : dx;
        major_end_q           <= x_major ? end_x_q : end_y_q;
        cnt_q                 <= '0;
      end
      StInit: begin
        err_q <= signed'({1'b0, delta_minor_q, 1'b0})
               - signed'({2'b00, delta_major_q});
      end
      StWalk: begin
        if (out_load) begin
          out_x_q    <= cur_x_q;
          out_y_q    <= cur_y_q;
          out_last_q <= major_hit;
          if (!walk_stop) begin
            cur_x_q <= nxt_x;
            cur_y_q <= nxt_y;
            err_q   <= nxt_err;
            cnt_q   <= cnt_q + CntW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutW'({out_y_q, out_x_q});
  assign m_axis_tlast  = out_last_q;

endmodule
